>>> rtl/core/least_squares_node_weights_assert.svh
// Assertion macros for the checker file of the node weight block.
`ifndef LEAST_SQUARES_NODE_WEIGHTS_ASSERT_SVH
`define LEAST_SQUARES_NODE_WEIGHTS_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LSNW_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LSNW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lsnw_pkg.sv
package lsnw_pkg;

    localparam int COORD_W  = 32;
    localparam int OFF_W    = COORD_W + 1;
    localparam int SUM_W    = OFF_W + 2;
    localparam int SQ_W     = 2 * OFF_W;
    localparam int MOM_W    = SQ_W + 2;
    localparam int DET_W    = 2 * MOM_W + 1;
    localparam int LAM_W    = SUM_W + MOM_W + 1;
    localparam int NUM_W    = LAM_W + SUM_W + 2;
    localparam int WGT_W    = 32;
    localparam int FRAC_W   = 28;
    localparam int QUO_W    = WGT_W + 2;
    localparam int MUL_CH   = 34;
    localparam int MUL_LAT  = 5;
    localparam int DIV_LAT  = QUO_W + 4;
    localparam int PIPE_LAT = 3 * MUL_LAT + 4 + DIV_LAT;
    localparam int NCELL    = 4;
    localparam int IN_W     = COORD_W * (2 + 2 * NCELL);
    localparam int OUT_W    = WGT_W * NCELL;
    localparam int USER_W   = 2;

    typedef struct packed {
        logic                         saturated;
        logic                         singular;
        logic [NCELL-1:0][WGT_W-1:0]  weight;
    } result_t;

endpackage

>>> rtl/core/lsnw_mul.sv
module lsnw_mul #(
    parameter int A_W  = lsnw_pkg::OFF_W,
    parameter int B_W  = lsnw_pkg::OFF_W,
    parameter int CH_W = lsnw_pkg::MUL_CH
) (
    input  logic                        aclk,
    input  logic                        ce,
    input  logic signed [A_W-1:0]       a,
    input  logic signed [B_W-1:0]       b,
    output logic signed [A_W+B_W-1:0]   p
);

    localparam int P_W   = A_W + B_W;
    localparam int NA    = (A_W + CH_W - 1) / CH_W;
    localparam int NB    = (B_W + CH_W - 1) / CH_W;
    localparam int AE_W  = NA * CH_W;
    localparam int BE_W  = NB * CH_W;
    localparam int ROW_W = BE_W + CH_W;
    localparam int TOT_W = AE_W + BE_W;

    logic [A_W-1:0]          ua;
    logic [B_W-1:0]          ub;
    logic [AE_W-1:0]         ma_reg;
    logic [BE_W-1:0]         mb_reg;
    logic [4:1]              sgn_reg;
    logic [2*CH_W-1:0]       pp_reg [NA][NB];
    logic [ROW_W-1:0]        row_reg [NA];
    logic [ROW_W-1:0]        row_next [NA];
    logic [TOT_W-1:0]        tot;
    logic [P_W-1:0]          mag_reg;
    logic signed [P_W-1:0]   p_reg;

    // Magnitudes are split into chunks; one partial product per chunk pair.
    always_comb begin
        ua = a[A_W-1] ? A_W'(-a) : A_W'(a);
        ub = b[B_W-1] ? B_W'(-b) : B_W'(b);
        for (int i = 0; i < NA; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++) begin
                row_next[i] = row_next[i] + (ROW_W'(pp_reg[i][j]) << (j * CH_W));
            end
        end
        tot = '0;
        for (int i = 0; i < NA; i++) begin
            tot = tot + (TOT_W'(row_reg[i]) << (i * CH_W));
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ma_reg  <= AE_W'(ua);
            mb_reg  <= BE_W'(ub);
            sgn_reg <= {sgn_reg[3:1], a[A_W-1] ^ b[B_W-1]};
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= (2*CH_W)'(ma_reg[i*CH_W +: CH_W])
                                  * (2*CH_W)'(mb_reg[j*CH_W +: CH_W]);
                end
            end
            row_reg <= row_next;
            mag_reg <= tot[P_W-1:0];
            p_reg   <= sgn_reg[4] ? -$signed(mag_reg) : $signed(mag_reg);
        end
    end

    assign p = p_reg;

endmodule

>>> rtl/core/lsnw_delay.sv
module lsnw_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic          aclk,
    input  logic          ce,
    input  logic [W-1:0]  d,
    output logic [W-1:0]  q
);

    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (ce) begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

>>> rtl/core/lsnw_div.sv
module lsnw_div #(
    parameter int N_W = lsnw_pkg::NUM_W
) (
    input  logic                               aclk,
    input  logic                               ce,
    input  logic signed [N_W-1:0]              num,
    input  logic signed [N_W-1:0]              den,
    output logic signed [lsnw_pkg::WGT_W-1:0]  w,
    output logic                               sat
);

    import lsnw_pkg::*;

    localparam int R_W = N_W + QUO_W + 1;

    logic [N_W-1:0]     um;
    logic [N_W-1:0]     ud;
    logic [R_W-1:0]     nm_reg;
    logic [N_W-1:0]     dm_reg;
    logic               neg_a_reg;

    logic [R_W-1:0]     r_reg   [QUO_W+1];
    logic [QUO_W-1:0]   q_reg   [QUO_W+1];
    logic [N_W-1:0]     d_reg   [QUO_W+1];
    logic               neg_reg [QUO_W+1];
    logic               ovf_reg [QUO_W+1];
    logic [R_W-1:0]     r_next  [QUO_W];
    logic [QUO_W-1:0]   q_next  [QUO_W];

    logic [QUO_W:0]     qr_reg;
    logic               ovf_r_reg;
    logic               neg_r_reg;
    logic [QUO_W:0]     lim;
    logic               sat_c;
    logic [QUO_W:0]     mag;
    logic [WGT_W-1:0]   w_reg;
    logic               sat_reg;

    // One restoring step per stage, most significant quotient bit first.
    always_comb begin
        um = num[N_W-1] ? N_W'(-num) : N_W'(num);
        ud = den[N_W-1] ? N_W'(-den) : N_W'(den);
        for (int k = 0; k < QUO_W; k++) begin
            logic [R_W-1:0] sub;
            sub = R_W'(d_reg[k]) << (QUO_W - 1 - k);
            if (r_reg[k] >= sub) begin
                r_next[k] = r_reg[k] - sub;
                q_next[k] = q_reg[k] | (QUO_W'(1) << (QUO_W - 1 - k));
            end else begin
                r_next[k] = r_reg[k];
                q_next[k] = q_reg[k];
            end
        end
        lim   = (QUO_W + 1)'(1) << (WGT_W - 1);
        lim   = neg_r_reg ? lim : lim - (QUO_W + 1)'(1);
        sat_c = ovf_r_reg || (qr_reg > lim);
        mag   = sat_c ? lim : qr_reg;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            nm_reg    <= R_W'(um) << FRAC_W;
            dm_reg    <= ud;
            neg_a_reg <= num[N_W-1] ^ den[N_W-1];

            // A quotient at or above 2^QUO_W is clipped in any case.
            r_reg[0]   <= nm_reg;
            q_reg[0]   <= '0;
            d_reg[0]   <= dm_reg;
            neg_reg[0] <= neg_a_reg;
            ovf_reg[0] <= nm_reg >= (R_W'(dm_reg) << QUO_W);

            for (int k = 0; k < QUO_W; k++) begin
                r_reg[k+1]   <= r_next[k];
                q_reg[k+1]   <= q_next[k];
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end

            // Round half away from zero on the magnitude.
            qr_reg    <= (QUO_W + 1)'(q_reg[QUO_W])
                       + (QUO_W + 1)'((r_reg[QUO_W] << 1) >= R_W'(d_reg[QUO_W]));
            ovf_r_reg <= ovf_reg[QUO_W];
            neg_r_reg <= neg_reg[QUO_W];

            w_reg   <= neg_r_reg ? WGT_W'(-mag[WGT_W-1:0]) : mag[WGT_W-1:0];
            sat_reg <= sat_c;
        end
    end

    assign w   = $signed(w_reg);
    assign sat = sat_reg;

endmodule

>>> rtl/core/lsnw_skid.sv
module lsnw_skid (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  lsnw_pkg::result_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output lsnw_pkg::result_t   out_data
);

    import lsnw_pkg::*;

    logic     out_valid_reg;
    logic     hold_valid_reg;
    result_t  out_data_reg;
    result_t  hold_data_reg;
    logic     free;
    logic     in_fire;

    assign in_ready = !hold_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign free     = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (free) begin
                out_valid_reg  <= hold_valid_reg || in_fire;
                hold_valid_reg <= 1'b0;
            end else if (in_fire) begin
                hold_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (free) begin
            out_data_reg <= hold_valid_reg ? hold_data_reg : in_data;
        end else if (in_fire) begin
            hold_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/core/least_squares_node_weights.sv
// Throughput: one item per cycle unless the output buffer is full; the 34-step divider
// pipelines and the chunked multiplier pipelines each take a new operand set every
// cycle in which the pipeline is enabled (ce).
// A two-entry output buffer keeps s_tready high while one result waits.
// Reset (aresetn low, synchronous) clears the pipeline and output buffer valid bits.
module least_squares_node_weights (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // node_x, node_y, cell0_x, cell0_y, cell1_x, cell1_y, cell2_x, cell2_y,
    // cell3_x, cell3_y
    input  logic [lsnw_pkg::IN_W-1:0]      s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // weight0, weight1, weight2, weight3
    output logic [lsnw_pkg::OUT_W-1:0]     m_tdata,
    // singular, saturated
    output logic [lsnw_pkg::USER_W-1:0]    m_tuser
);

    import lsnw_pkg::*;

    logic                        ce;
    logic                        s_fire;
    logic [PIPE_LAT-1:0]         vld_reg;

    logic signed [COORD_W-1:0]   nx;
    logic signed [COORD_W-1:0]   ny;
    logic signed [COORD_W-1:0]   cx [NCELL];
    logic signed [COORD_W-1:0]   cy [NCELL];

    logic signed [OFF_W-1:0]     jx_reg [NCELL];
    logic signed [OFF_W-1:0]     jy_reg [NCELL];
    logic signed [SUM_W-1:0]     rx_reg;
    logic signed [SUM_W-1:0]     ry_reg;
    logic signed [SQ_W-1:0]      sxx [NCELL];
    logic signed [SQ_W-1:0]      syy [NCELL];
    logic signed [SQ_W-1:0]      sxy [NCELL];
    logic signed [MOM_W-1:0]     ixx_reg;
    logic signed [MOM_W-1:0]     iyy_reg;
    logic signed [MOM_W-1:0]     ixy_reg;

    logic [2*SUM_W-1:0]          r7_d;
    logic [2*SUM_W-1:0]          r13_d;
    logic signed [SUM_W-1:0]     rx7, ry7, rx13, ry13;
    logic [2*NCELL*OFF_W-1:0]    j_pack;
    logic [2*NCELL*OFF_W-1:0]    j13_d;
    logic signed [OFF_W-1:0]     jx13 [NCELL];
    logic signed [OFF_W-1:0]     jy13 [NCELL];

    logic signed [2*MOM_W-1:0]        p_ii, p_xy2;
    logic signed [SUM_W+MOM_W-1:0]    p_ryixy, p_rxiyy, p_rxixy, p_ryixx;
    logic signed [DET_W-1:0]          det_reg;
    logic signed [LAM_W-1:0]          lx_reg;
    logic signed [LAM_W-1:0]          ly_reg;
    logic [DET_W-1:0]                 det18_d;
    logic signed [DET_W-1:0]          det18;

    logic signed [LAM_W+OFF_W-1:0]    ax [NCELL];
    logic signed [LAM_W+OFF_W-1:0]    ay [NCELL];
    logic signed [LAM_W+SUM_W-1:0]    brx, bry;
    logic signed [NUM_W-1:0]          num_reg [NCELL];
    logic signed [NUM_W-1:0]          den_reg;
    logic signed [DET_W-1:0]          det19_reg;
    logic                             sing_reg;
    logic                             sing_out;

    logic signed [WGT_W-1:0]          w [NCELL];
    logic [NCELL-1:0]                 sat;
    result_t                          res;
    result_t                          out_res;

    assign s_tready = ce;
    assign s_fire   = s_tvalid && ce;

    always_comb begin
        nx = $signed(s_tdata[0 +: COORD_W]);
        ny = $signed(s_tdata[COORD_W +: COORD_W]);
        for (int k = 0; k < NCELL; k++) begin
            cx[k] = $signed(s_tdata[(2 + 2*k) * COORD_W +: COORD_W]);
            cy[k] = $signed(s_tdata[(3 + 2*k) * COORD_W +: COORD_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_fire};
        end
    end

    // Offsets, sums and the second moments.
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < NCELL; k++) begin
                jx_reg[k] <= OFF_W'(cx[k]) - OFF_W'(nx);
                jy_reg[k] <= OFF_W'(cy[k]) - OFF_W'(ny);
            end
            rx_reg <= SUM_W'(jx_reg[0]) + SUM_W'(jx_reg[1])
                    + SUM_W'(jx_reg[2]) + SUM_W'(jx_reg[3]);
            ry_reg <= SUM_W'(jy_reg[0]) + SUM_W'(jy_reg[1])
                    + SUM_W'(jy_reg[2]) + SUM_W'(jy_reg[3]);
            ixx_reg <= MOM_W'(sxx[0]) + MOM_W'(sxx[1]) + MOM_W'(sxx[2]) + MOM_W'(sxx[3]);
            iyy_reg <= MOM_W'(syy[0]) + MOM_W'(syy[1]) + MOM_W'(syy[2]) + MOM_W'(syy[3]);
            ixy_reg <= MOM_W'(sxy[0]) + MOM_W'(sxy[1]) + MOM_W'(sxy[2]) + MOM_W'(sxy[3]);
        end
    end

    for (genvar k = 0; k < NCELL; k++) begin : g_sq
        lsnw_mul #(.A_W(OFF_W), .B_W(OFF_W), .CH_W(MUL_CH)) u_xx (
            .aclk(aclk), .ce(ce), .a(jx_reg[k]), .b(jx_reg[k]), .p(sxx[k]));
        lsnw_mul #(.A_W(OFF_W), .B_W(OFF_W), .CH_W(MUL_CH)) u_yy (
            .aclk(aclk), .ce(ce), .a(jy_reg[k]), .b(jy_reg[k]), .p(syy[k]));
        lsnw_mul #(.A_W(OFF_W), .B_W(OFF_W), .CH_W(MUL_CH)) u_xy (
            .aclk(aclk), .ce(ce), .a(jx_reg[k]), .b(jy_reg[k]), .p(sxy[k]));
    end

    lsnw_delay #(.W(2*SUM_W), .DEPTH(MUL_LAT)) u_r7 (
        .aclk(aclk), .ce(ce), .d({rx_reg, ry_reg}), .q(r7_d));
    assign {rx7, ry7} = r7_d;

    lsnw_delay #(.W(2*SUM_W), .DEPTH(MUL_LAT + 1)) u_r13 (
        .aclk(aclk), .ce(ce), .d(r7_d), .q(r13_d));
    assign {rx13, ry13} = r13_d;

    always_comb begin
        for (int k = 0; k < NCELL; k++) begin
            j_pack[(2*k) * OFF_W +: OFF_W]     = jx_reg[k];
            j_pack[(2*k + 1) * OFF_W +: OFF_W] = jy_reg[k];
            jx13[k] = $signed(j13_d[(2*k) * OFF_W +: OFF_W]);
            jy13[k] = $signed(j13_d[(2*k + 1) * OFF_W +: OFF_W]);
        end
    end

    lsnw_delay #(.W(2*NCELL*OFF_W), .DEPTH(2*MUL_LAT + 2)) u_j13 (
        .aclk(aclk), .ce(ce), .d(j_pack), .q(j13_d));

    // Determinant and the scaled multipliers Lx = D*lx, Ly = D*ly.
    lsnw_mul #(.A_W(MOM_W), .B_W(MOM_W), .CH_W(MUL_CH)) u_ii (
        .aclk(aclk), .ce(ce), .a(ixx_reg), .b(iyy_reg), .p(p_ii));
    lsnw_mul #(.A_W(MOM_W), .B_W(MOM_W), .CH_W(MUL_CH)) u_xy2 (
        .aclk(aclk), .ce(ce), .a(ixy_reg), .b(ixy_reg), .p(p_xy2));
    lsnw_mul #(.A_W(SUM_W), .B_W(MOM_W), .CH_W(MUL_CH)) u_ryixy (
        .aclk(aclk), .ce(ce), .a(ry7), .b(ixy_reg), .p(p_ryixy));
    lsnw_mul #(.A_W(SUM_W), .B_W(MOM_W), .CH_W(MUL_CH)) u_rxiyy (
        .aclk(aclk), .ce(ce), .a(rx7), .b(iyy_reg), .p(p_rxiyy));
    lsnw_mul #(.A_W(SUM_W), .B_W(MOM_W), .CH_W(MUL_CH)) u_rxixy (
        .aclk(aclk), .ce(ce), .a(rx7), .b(ixy_reg), .p(p_rxixy));
    lsnw_mul #(.A_W(SUM_W), .B_W(MOM_W), .CH_W(MUL_CH)) u_ryixx (
        .aclk(aclk), .ce(ce), .a(ry7), .b(ixx_reg), .p(p_ryixx));

    always_ff @(posedge aclk) begin
        if (ce) begin
            det_reg <= DET_W'(p_ii) - DET_W'(p_xy2);
            lx_reg  <= LAM_W'(p_ryixy) - LAM_W'(p_rxiyy);
            ly_reg  <= LAM_W'(p_rxixy) - LAM_W'(p_ryixx);
        end
    end

    lsnw_delay #(.W(DET_W), .DEPTH(MUL_LAT)) u_det18 (
        .aclk(aclk), .ce(ce), .d(det_reg), .q(det18_d));
    assign det18 = $signed(det18_d);

    for (genvar k = 0; k < NCELL; k++) begin : g_lam
        lsnw_mul #(.A_W(LAM_W), .B_W(OFF_W), .CH_W(MUL_CH)) u_ax (
            .aclk(aclk), .ce(ce), .a(lx_reg), .b(jx13[k]), .p(ax[k]));
        lsnw_mul #(.A_W(LAM_W), .B_W(OFF_W), .CH_W(MUL_CH)) u_ay (
            .aclk(aclk), .ce(ce), .a(ly_reg), .b(jy13[k]), .p(ay[k]));
    end

    lsnw_mul #(.A_W(LAM_W), .B_W(SUM_W), .CH_W(MUL_CH)) u_brx (
        .aclk(aclk), .ce(ce), .a(lx_reg), .b(rx13), .p(brx));
    lsnw_mul #(.A_W(LAM_W), .B_W(SUM_W), .CH_W(MUL_CH)) u_bry (
        .aclk(aclk), .ce(ce), .a(ly_reg), .b(ry13), .p(bry));

    // Numerators D + Lx*Jx + Ly*Jy and the shared denominator 4D + Lx*Rx + Ly*Ry.
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < NCELL; k++) begin
                num_reg[k] <= NUM_W'(det18) + NUM_W'(ax[k]) + NUM_W'(ay[k]);
            end
            den_reg   <= (NUM_W'(det18) <<< 2) + NUM_W'(brx) + NUM_W'(bry);
            det19_reg <= det18;
            sing_reg  <= (det19_reg == '0) || (den_reg == '0);
        end
    end

    for (genvar k = 0; k < NCELL; k++) begin : g_div
        lsnw_div #(.N_W(NUM_W)) u_div (
            .aclk(aclk), .ce(ce), .num(num_reg[k]), .den(den_reg),
            .w(w[k]), .sat(sat[k]));
    end

    lsnw_delay #(.W(1), .DEPTH(DIV_LAT - 1)) u_sing (
        .aclk(aclk), .ce(ce), .d(sing_reg), .q(sing_out));

    always_comb begin
        res.singular  = sing_out;
        res.saturated = !sing_out && (|sat);
        for (int k = 0; k < NCELL; k++) begin
            res.weight[k] = sing_out ? '0 : w[k];
        end
    end

    lsnw_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld_reg[PIPE_LAT-1]),
        .in_ready  (ce),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = out_res.weight;
    assign m_tuser = {out_res.saturated, out_res.singular};

endmodule

>>> rtl/core/lsnw_checker.sv
`include "least_squares_node_weights_assert.svh"

module lsnw_port_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [lsnw_pkg::OUT_W-1:0]     m_tdata,
    input  logic [lsnw_pkg::USER_W-1:0]    m_tuser
);

    import lsnw_pkg::*;

    logic                         stall;
    logic                         sing_item;
    logic                         sat_item;
    logic                         clean_zero;
    logic                         any_limit;
    logic [NCELL-1:0]             at_limit;
    logic [USER_W+OUT_W-1:0]      m_item;

    always_comb begin
        stall      = m_tvalid && !m_tready;
        sing_item  = m_tvalid && m_tuser[0];
        sat_item   = m_tvalid && m_tuser[1];
        clean_zero = (m_tdata == '0) && !m_tuser[1];
        m_item     = {m_tuser, m_tdata};
        for (int k = 0; k < NCELL; k++) begin
            at_limit[k] = (m_tdata[k*WGT_W +: WGT_W] == {1'b0, {(WGT_W-1){1'b1}}})
                       || (m_tdata[k*WGT_W +: WGT_W] == {1'b1, {(WGT_W-1){1'b0}}});
        end
        any_limit = |at_limit;
    end

    // A stalled item keeps its payload.
    `LSNW_ASSERT_NEXT(a_hold, aclk, aresetn, stall, m_tvalid && $stable(m_item), "held item changed")

    // A singular item carries zero weights and no clipping.
    `LSNW_ASSERT_NOW(a_singular_zero, aclk, aresetn, sing_item, clean_zero, "singular item not zero")

    // A clipped item shows at least one weight at a range limit.
    `LSNW_ASSERT_NOW(a_sat_limit, aclk, aresetn, sat_item, any_limit, "clipped item without limit")

    // The input side only stalls after the output side held back an item.
    `LSNW_ASSERT_NOW(a_ready_fall, aclk, aresetn, $fell(s_tready), $past(stall), "early input stall")

endmodule

bind least_squares_node_weights lsnw_port_checker u_lsnw_checker (.*);

>>> tb/sv/lsnw_checker.sv
`timescale 1ns / 1ps

// Watches both streams of the node weight block, works out the weights of
// every accepted node item and compares them with the results in order.
module lsnw_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [lsnw_pkg::IN_W-1:0]      s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [lsnw_pkg::OUT_W-1:0]     m_tdata,
    input  logic [lsnw_pkg::USER_W-1:0]    m_tuser,
    output int                             pending_cnt,
    output int                             error_cnt
);
    import lsnw_pkg::*;

    result_t weights_due[$];

    // Exact weights: w_k = (D + Lx*Jx_k + Ly*Jy_k) / (4*D + Lx*Rx + Ly*Ry),
    // rounded half away from zero to Q4.28 and clipped.
    function automatic result_t node_weights(logic [IN_W-1:0] item);
        logic signed [255:0] nx, ny, rx, ry, ixx, iyy, ixy;
        logic signed [255:0] det, lx, ly, den, num, mag, dvs, quo, rmd, lim;
        logic signed [255:0] jx [NCELL];
        logic signed [255:0] jy [NCELL];
        logic neg;
        result_t res;
        nx = $signed(item[0 +: COORD_W]);
        ny = $signed(item[COORD_W +: COORD_W]);
        rx = 0; ry = 0; ixx = 0; iyy = 0; ixy = 0;
        for (int k = 0; k < NCELL; k++) begin
            jx[k] = $signed(item[(2 + 2 * k) * COORD_W +: COORD_W]);
            jy[k] = $signed(item[(3 + 2 * k) * COORD_W +: COORD_W]);
            jx[k] = jx[k] - nx;
            jy[k] = jy[k] - ny;
            rx  = rx + jx[k];
            ry  = ry + jy[k];
            ixx = ixx + jx[k] * jx[k];
            iyy = iyy + jy[k] * jy[k];
            ixy = ixy + jx[k] * jy[k];
        end
        det = ixx * iyy - ixy * ixy;
        lx  = ry * ixy - rx * iyy;
        ly  = rx * ixy - ry * ixx;
        den = 4 * det + lx * rx + ly * ry;
        res = '0;
        if (det == 0 || den == 0) begin
            res.singular = 1'b1;
            return res;
        end
        dvs = (den < 0) ? -den : den;
        for (int k = 0; k < NCELL; k++) begin
            num = det + lx * jx[k] + ly * jy[k];
            neg = (num < 0) != (den < 0);
            mag = (num < 0) ? -num : num;
            mag = mag <<< FRAC_W;
            quo = mag / dvs;
            rmd = mag % dvs;
            if ((rmd <<< 1) >= dvs) quo = quo + 1;
            lim = neg ? 256'sh8000_0000 : 256'sh7FFF_FFFF;
            if (quo > lim) begin
                quo = lim;
                res.saturated = 1'b1;
            end
            if (neg) quo = -quo;
            res.weight[k] = quo[WGT_W-1:0];
        end
        return res;
    endfunction

    assign pending_cnt = weights_due.size();

    always @(posedge aclk) begin
        result_t want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            weights_due.delete();
            error_cnt <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (weights_due.size() == 0) begin
                    $error("result item with no node item outstanding");
                    errs++;
                end else begin
                    want = weights_due.pop_front();
                    for (int k = 0; k < NCELL; k++) begin
                        if (m_tdata[k * WGT_W +: WGT_W] !== want.weight[k]) begin
                            $error("weight%0d expected %h actual %h", k, want.weight[k],
                                   m_tdata[k * WGT_W +: WGT_W]);
                            errs++;
                        end
                    end
                    if (m_tuser[0] !== want.singular) begin
                        $error("singular expected %b actual %b", want.singular, m_tuser[0]);
                        errs++;
                    end
                    if (m_tuser[1] !== want.saturated) begin
                        $error("saturated expected %b actual %b", want.saturated,
                               m_tuser[1]);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                weights_due.push_back(node_weights(s_tdata));
            error_cnt <= error_cnt + errs;
        end
    end

endmodule

>>> tb/sv/tb_least_squares_node_weights.sv
`timescale 1ns / 1ps

module tb_least_squares_node_weights;
    import lsnw_pkg::*;

    localparam int N_RANDOM    = 780;
    localparam int QUIET_TAIL  = 120;
    localparam int HOLD_CYCLES = 300;
    localparam int ONE         = 65536;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic [USER_W-1:0]     m_tuser;
    int                    pending_cnt;
    int                    error_cnt;
    bit                    quiet;
    bit                    hold_req;
    bit                    hold_done = 1'b0;

    least_squares_node_weights DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lsnw_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .pending_cnt (pending_cnt),
        .error_cnt   (error_cnt)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("FAIL");
        $finish;
    end

    // Offers one node item, with a random gap in front unless the tail is quiet.
    task automatic send_node(int nx, int ny, int c0x, int c0y, int c1x, int c1y,
                             int c2x, int c2y, int c3x, int c3y);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {c3y, c3x, c2y, c2x, c1y, c1x, c0y, c0x, ny, nx};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return $urandom();
        endcase
    endfunction

    // Receiver: random stall bursts, one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
                repeat ($urandom_range(1, 8) - 1) @(negedge aclk);
            end
        end
    end

    initial begin
        int nx, ny, h, jit, cnt;
        int c [8];
        s_tvalid = 1'b0;
        s_tdata  = '0;
        quiet    = 1'b0;
        hold_req = 1'b0;
        aresetn  = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: regular square, all coincident, collinear cells, extremes.
        send_node(0, 0, -ONE, ONE, ONE, ONE, -ONE, -ONE, ONE, -ONE);
        send_node(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_node(5, 5, 5, 5, 5, 5, 5, 5, 5, 5);
        send_node(0, 0, ONE, 0, 2 * ONE, 0, 3 * ONE, 0, -ONE, 0);
        send_node(0, 0, ONE, ONE, 2 * ONE, 2 * ONE, -ONE, -ONE, 3 * ONE, 3 * ONE);
        send_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000);
        send_node(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_node(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  0, 0);
        send_node(-1, -1, 0, 0, -1, 0, 0, -1, 1, 1);
        // Nearly collinear cells with the node off to one side give huge weights.
        send_node(0, 10 * ONE, 0, 0, ONE, 0, 2 * ONE, 0, 3 * ONE, 1);
        send_node(0, 0, ONE, 0, 0, ONE, 2 * ONE, 1, 1, 2 * ONE);
        send_node(3 * ONE, 0, 0, 0, ONE, 1, 2 * ONE, 0, -ONE, 0);
        send_node(ONE / 2, ONE / 3, -ONE, ONE, ONE, ONE, -ONE, -ONE, ONE, -ONE);
        send_node(0, 0, 1, 0, 0, 1, -1, 0, 0, -1);

        // Random: mostly skewed mesh quads around a node, some raw noise.
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 200) hold_req = 1'b1;
            if (i == N_RANDOM - QUIET_TAIL) begin
                wait (hold_done);
                quiet = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1: begin
                    for (int k = 0; k < 8; k++) c[k] = $urandom();
                    nx = $urandom();
                    ny = $urandom();
                end
                2: begin
                    for (int k = 0; k < 8; k++) c[k] = pick_extreme();
                    nx = pick_extreme();
                    ny = pick_extreme();
                end
                3: begin
                    // Degenerate quads: cells evenly spaced on one horizontal or diagonal line.
                    nx = $urandom_range(0, 1 << 20) - (1 << 19);
                    ny = $urandom_range(0, 1 << 20) - (1 << 19);
                    h = $urandom_range(1, ONE);
                    jit = $urandom_range(0, 1);
                    for (int k = 0; k < 4; k++) begin
                        c[2 * k]     = nx + k * h;
                        c[2 * k + 1] = jit ? ny : ny + k * h;
                    end
                end
                default: begin
                    h = 1 << $urandom_range(0, 24);
                    h = h + $urandom_range(0, h);
                    jit = h / 2;
                    nx = $urandom_range(0, 1 << 28) - (1 << 27);
                    ny = $urandom_range(0, 1 << 28) - (1 << 27);
                    c[0] = nx - h; c[1] = ny + h;
                    c[2] = nx + h; c[3] = ny + h;
                    c[4] = nx - h; c[5] = ny - h;
                    c[6] = nx + h; c[7] = ny - h;
                    for (int k = 0; k < 8; k++)
                        c[k] = c[k] + $urandom_range(0, 2 * jit) - jit;
                end
            endcase
            send_node(nx, ny, c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
        end
        s_tvalid = 1'b0;

        cnt = 0;
        while (pending_cnt != 0 && cnt < 100000) begin
            @(negedge aclk);
            cnt++;
        end
        repeat (PIPE_LAT + 20) @(negedge aclk);
        if (error_cnt == 0 && pending_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
